// ===== rtl/core/accel_calibrate_tilt_angles_macros.svh =====
// Assertion macros shared by the tilt-angle block.
`ifndef ACCEL_CALIBRATE_TILT_ANGLES_MACROS_SVH
`define ACCEL_CALIBRATE_TILT_ANGLES_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ACT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Condition now implies the earlier condition, as $past sees it at depth n.
`define ACT_ASSERT_PAST(label, clk, rst_n, now_c, then_c, n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (now_c) |-> $past(then_c, n)) \
    else $error("assertion failed: history");

`endif

// ===== rtl/core/act_pkg.sv =====
// Types, constants and tables for the tilt-angle block.
`timescale 1ns / 1ps
package act_pkg;

  localparam int AXIS_W = 16;
  localparam int ANG_W  = 15;
  localparam int COEF_W = 29;
  localparam int PROD_W = AXIS_W + COEF_W;
  localparam int ACC_W  = 48;
  localparam int CAL_FRAC = 24;
  localparam int SQ_W   = 32;
  localparam int RAD_W  = SQ_W + 16;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CV_W   = 27;
  localparam int CZ_W   = 25;
  localparam int ATAN_W = 22;
  localparam int ZC_W   = 23;
  localparam int SQRT_STEPS = ROOT_W;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } sample_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
    logic [RAD_W-1:0]  v;
  } sqrt_t;

  typedef struct packed {
    logic signed [CV_W-1:0] x;
    logic signed [CV_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_t;

  localparam coef_t COEF [3][3] = '{
    '{ 29'sd139024418, -29'sd2937857,   -29'sd359712    },
    '{ -29'sd3047554,   29'sd131843208, -29'sd644159    },
    '{ -29'sd546553,   -29'sd1176363,    29'sd136274205 }
  };

  localparam acc_t OFFSET [3] = '{
    -48'sd3358201428, -48'sd1449062442, -48'sd2841948297
  };

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (CAL_FRAC - 1);
  localparam logic [ZC_W-1:0] ANG_MAX_FINE = 23'd5898240;
  localparam logic [ZC_W-1:0] ANG_HALF = 23'd256;

  function automatic logic [ATAN_W-1:0] atan_step(input logic [4:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/act_front.sv =====
// Calibration matrix, saturation, squares and root radicands.
`timescale 1ns / 1ps
module act_front (
  input  logic                         clk,
  input  act_pkg::sample_t             raw,
  output act_pkg::sample_t             cal,
  output logic [act_pkg::RAD_W-1:0]    rad_pitch,
  output logic [act_pkg::RAD_W-1:0]    rad_roll
);

  act_pkg::prod_t              prod_r [3][3];
  act_pkg::sample_t            cal_r;
  act_pkg::sample_t            cal_nxt;
  logic [act_pkg::SQ_W-1:0]    sq_r [3];
  logic [act_pkg::RAD_W-1:0]   rad_pitch_r;
  logic [act_pkg::RAD_W-1:0]   rad_roll_r;
  act_pkg::axis_t              raw_a [3];
  act_pkg::axis_t              cal_a [3];
  act_pkg::axis_t              cal_q [3];

  assign raw_a[0] = raw.x;
  assign raw_a[1] = raw.y;
  assign raw_a[2] = raw.z;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[r][c] <= act_pkg::prod_t'(raw_a[c]) * act_pkg::prod_t'(act_pkg::COEF[r][c]);
      end
    end
  end

  always_comb begin
    act_pkg::acc_t s;
    logic signed [act_pkg::ACC_W-act_pkg::CAL_FRAC-1:0] q;
    for (int r = 0; r < 3; r++) begin
      s = act_pkg::acc_t'(prod_r[r][0]) + act_pkg::acc_t'(prod_r[r][1])
        + act_pkg::acc_t'(prod_r[r][2]) + act_pkg::OFFSET[r] + act_pkg::ROUND_HALF;
      q = s[act_pkg::ACC_W-1:act_pkg::CAL_FRAC];
      if (q > 24'sd32767) begin
        cal_q[r] = 16'sh7fff;
      end else if (q < -24'sd32768) begin
        cal_q[r] = -16'sh8000;
      end else begin
        cal_q[r] = q[act_pkg::AXIS_W-1:0];
      end
    end
    cal_nxt.x = cal_q[0];
    cal_nxt.y = cal_q[1];
    cal_nxt.z = cal_q[2];
  end

  always_ff @(posedge clk) begin
    cal_r <= cal_nxt;
  end

  assign cal_a[0] = cal_r.x;
  assign cal_a[1] = cal_r.y;
  assign cal_a[2] = cal_r.z;

  always_ff @(posedge clk) begin
    logic signed [act_pkg::SQ_W-1:0] p;
    for (int k = 0; k < 3; k++) begin
      p = act_pkg::SQ_W'(cal_a[k]) * act_pkg::SQ_W'(cal_a[k]);
      sq_r[k] <= p;
    end
  end

  always_ff @(posedge clk) begin
    rad_pitch_r <= {sq_r[1] + sq_r[2], 16'd0};
    rad_roll_r  <= {sq_r[0] + sq_r[2], 16'd0};
  end

  assign cal       = cal_r;
  assign rad_pitch = rad_pitch_r;
  assign rad_roll  = rad_roll_r;

endmodule

// ===== rtl/core/act_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
module act_sqrt_cell (
  input  logic            clk,
  input  act_pkg::sqrt_t  d_in,
  output act_pkg::sqrt_t  d_out
);

  act_pkg::sqrt_t d_r;
  act_pkg::sqrt_t d_nxt;

  always_comb begin
    logic [act_pkg::REM_W+1:0] rem_sh;
    logic [act_pkg::REM_W+1:0] trial;
    rem_sh = {d_in.rem, d_in.v[act_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, d_in.q, 2'b01};
    d_nxt.v = {d_in.v[act_pkg::RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem = act_pkg::REM_W'(rem_sh - trial);
      d_nxt.q   = {d_in.q[act_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem = rem_sh[act_pkg::REM_W-1:0];
      d_nxt.q   = {d_in.q[act_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== rtl/core/act_cordic_cell.sv =====
// One rotation cell of the CORDIC vectoring chain.
`timescale 1ns / 1ps
module act_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  act_pkg::cordic_t  d_in,
  output act_pkg::cordic_t  d_out
);

  act_pkg::cordic_t d_r;
  act_pkg::cordic_t d_nxt;

  always_comb begin
    logic signed [act_pkg::CV_W-1:0] xs;
    logic signed [act_pkg::CV_W-1:0] ys;
    logic signed [act_pkg::CZ_W-1:0] da;
    xs = d_in.x >>> STEP;
    ys = d_in.y >>> STEP;
    da = act_pkg::CZ_W'(act_pkg::atan_step(5'(STEP)));
    if (!d_in.y[act_pkg::CV_W-1] && (d_in.y != '0)) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + da;
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - da;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

// ===== rtl/core/accel_calibrate_tilt_angles.sv =====
// Top level: calibrated axes and tilt angles from one accelerometer sample.
//
// Raise start with in_raw_x/y/z; busy stays low, so a sample is taken on
// every cycle that start is high. Each beat passes a calibration front of
// four register stages, a chain of 24 square-root digit cells and a chain
// of CORDIC_STEPS rotation cells, then one output register.
// Throughput is one sample per cycle, set by the one-stage-per-cell
// chains.
// out_valid marks a result for exactly one cycle; the receiver cannot stall
// and results leave in the order samples came in.
// Reset clears the valid line only; beats in flight are dropped.
// Pitch and roll come in 1/128 degree, calibrated axes in 1/8192 g.
`timescale 1ns / 1ps
`include "accel_calibrate_tilt_angles_macros.svh"
module accel_calibrate_tilt_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  act_pkg::axis_t  in_raw_x,
  input  act_pkg::axis_t  in_raw_y,
  input  act_pkg::axis_t  in_raw_z,
  output logic            out_valid,
  output act_pkg::axis_t  out_cal_x,
  output act_pkg::axis_t  out_cal_y,
  output act_pkg::axis_t  out_cal_z,
  output act_pkg::ang_t   out_pitch,
  output act_pkg::ang_t   out_roll
);

  localparam int PIPE    = 5 + act_pkg::SQRT_STEPS + CORDIC_STEPS;
  localparam int CAL_LEN = 2 + act_pkg::SQRT_STEPS + CORDIC_STEPS;
  localparam int CAL_TAP = 1 + act_pkg::SQRT_STEPS;

  logic [PIPE-1:0]   v_r;
  logic [PIPE-1:0]   v_nxt;
  act_pkg::sample_t  raw;
  act_pkg::sample_t  cal_f;
  act_pkg::sample_t  cal_d_r [CAL_LEN];
  logic [act_pkg::RAD_W-1:0] rad [2];
  act_pkg::sqrt_t    sq_chain [2][act_pkg::SQRT_STEPS+1];
  act_pkg::cordic_t  co_chain [2][CORDIC_STEPS+1];
  act_pkg::axis_t    num_in [2];
  act_pkg::axis_t    num_out [2];
  act_pkg::ang_t     ang_nxt [2];
  act_pkg::ang_t     ang_r [2];
  act_pkg::sample_t  cal_out_r;

  assign busy = 1'b0;
  assign raw  = '{x: in_raw_x, y: in_raw_y, z: in_raw_z};

  assign v_nxt = {v_r[PIPE-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  act_front u_front (
    .clk       (clk),
    .raw       (raw),
    .cal       (cal_f),
    .rad_pitch (rad[0]),
    .rad_roll  (rad[1])
  );

  always_ff @(posedge clk) begin
    cal_d_r[0] <= cal_f;
    for (int m = 1; m < CAL_LEN; m++) begin
      cal_d_r[m] <= cal_d_r[m-1];
    end
  end

  assign num_in[0]  = cal_d_r[CAL_TAP].x;
  assign num_in[1]  = cal_d_r[CAL_TAP].y;
  assign num_out[0] = cal_d_r[CAL_LEN-1].x;
  assign num_out[1] = cal_d_r[CAL_LEN-1].y;

  for (genvar a = 0; a < 2; a++) begin : g_angle
    logic [act_pkg::AXIS_W-1:0] mag;

    assign sq_chain[a][0] = '{rem: '0, q: '0, v: rad[a]};

    for (genvar k = 0; k < act_pkg::SQRT_STEPS; k++) begin : g_sqrt
      act_sqrt_cell u_cell (
        .clk   (clk),
        .d_in  (sq_chain[a][k]),
        .d_out (sq_chain[a][k+1])
      );
    end

    assign mag = num_in[a][act_pkg::AXIS_W-1] ? act_pkg::AXIS_W'(-num_in[a])
                                              : num_in[a];
    assign co_chain[a][0].x = {3'b000, sq_chain[a][act_pkg::SQRT_STEPS].q};
    assign co_chain[a][0].y = {3'b000, mag, 8'd0};
    assign co_chain[a][0].z = '0;

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      act_cordic_cell #(.STEP(j)) u_cell (
        .clk   (clk),
        .d_in  (co_chain[a][j]),
        .d_out (co_chain[a][j+1])
      );
    end

    always_comb begin
      logic signed [act_pkg::CZ_W-1:0] z;
      logic [act_pkg::ZC_W-1:0] zc;
      logic [act_pkg::ZC_W-1:0] zr;
      logic [act_pkg::ANG_W-1:0] mag_ang;
      z = co_chain[a][CORDIC_STEPS].z;
      if (z[act_pkg::CZ_W-1]) begin
        zc = '0;
      end else if (z[act_pkg::ZC_W-1:0] > act_pkg::ANG_MAX_FINE || z[act_pkg::CZ_W-2]) begin
        zc = act_pkg::ANG_MAX_FINE;
      end else begin
        zc = z[act_pkg::ZC_W-1:0];
      end
      zr = zc + act_pkg::ANG_HALF;
      mag_ang = {1'b0, zr[act_pkg::ZC_W-1:9]};
      ang_nxt[a] = num_out[a][act_pkg::AXIS_W-1] ? -$signed(mag_ang) : $signed(mag_ang);
    end

    always_ff @(posedge clk) begin
      ang_r[a] <= ang_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    cal_out_r <= cal_d_r[CAL_LEN-1];
  end

  assign out_valid = v_r[PIPE-1];
  assign out_cal_x = cal_out_r.x;
  assign out_cal_y = cal_out_r.y;
  assign out_cal_z = cal_out_r.z;
  assign out_pitch = ang_r[0];
  assign out_roll  = ang_r[1];

  `ACT_ASSERT_PAST(a_latency, clk, rst_n, out_valid, start && !busy, PIPE)
  `ACT_ASSERT_IMPL(a_pitch_range, clk, rst_n, out_valid, (out_pitch <= 15'sd11520) && (out_pitch >= -15'sd11520))
  `ACT_ASSERT_IMPL(a_pitch_sign, clk, rst_n, out_valid && out_cal_x[15], out_pitch <= 15'sd0)
  `ACT_ASSERT_IMPL(a_roll_sign, clk, rst_n, out_valid && !out_cal_y[15], out_roll >= 15'sd0)

endmodule
